@@ rtl/dnapk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dnapk_pkg;

   // action codes
   localparam logic ACTION_BASE  = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   // one-hot nucleotide codes
   localparam logic [3:0] NT_A = 4'd1;
   localparam logic [3:0] NT_C = 4'd2;
   localparam logic [3:0] NT_G = 4'd4;
   localparam logic [3:0] NT_T = 4'd8;

   localparam int BYTE_ADDR_BITS = 30;
   localparam int RUN_BITS       = 32;
   localparam int REF_LEN_BITS   = 32;

   typedef struct packed {
      logic       action;
      logic [3:0] base_code;
   } req_type;

   typedef struct packed {
      logic                      byte_valid;
      logic [7:0]                packed_byte;
      logic [BYTE_ADDR_BITS-1:0] byte_address;
      logic                      run_valid;
      logic [RUN_BITS-1:0]       run_start;
      logic [RUN_BITS-1:0]       run_length;
      logic                      length_error;
   } rsp_type;

   typedef struct packed {
      logic [1:0] code;
      logic       ambiguous;
   } base_decode_type;

   function automatic base_decode_type decode_base(input logic [3:0] base_code);
      base_decode_type d;
      d.ambiguous = 1'b0;
      unique case (base_code)
         NT_A:    d.code = 2'd0;
         NT_C:    d.code = 2'd1;
         NT_G:    d.code = 2'd2;
         NT_T:    d.code = 2'd3;
         default: begin
            d.code      = 2'd0;
            d.ambiguous = 1'b1;
         end
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

@@ rtl/dnapk_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface dnapk_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [3:0] base_code;

   modport source (output valid, output action, output base_code, input ready);
   modport sink   (input valid, input action, input base_code, output ready);
endinterface

interface dnapk_rsp_if;
   logic        valid;
   logic        ready;
   logic        byte_valid;
   logic [7:0]  packed_byte;
   logic [29:0] byte_address;
   logic        run_valid;
   logic [31:0] run_start;
   logic [31:0] run_length;
   logic        length_error;

   modport source (output valid, output byte_valid, output packed_byte,
                   output byte_address, output run_valid, output run_start,
                   output run_length, output length_error, input ready);
   modport sink   (input valid, input byte_valid, input packed_byte,
                   input byte_address, input run_valid, input run_start,
                   input run_length, input length_error, output ready);
endinterface

interface dnapk_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] reference_length;

   modport source (output valid, output reference_length, input ready);
   modport sink   (input valid, input reference_length, output ready);
endinterface

`default_nettype wire

@@ rtl/dnapk_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Next-state and result logic for one request.
module dnapk_step #(
   parameter int POSITION_BITS = 32
) (
   input  wire dnapk_pkg::req_type         item,
   input  wire [31:0]                      ref_len,
   input  wire [5:0]                       acc,
   input  wire [1:0]                       held,
   input  wire [POSITION_BITS-1:0]         pos,
   input  wire [29:0]                      addr,
   input  wire                             run_open,
   input  wire [POSITION_BITS-1:0]         run_start,
   output logic                            has_result,
   output dnapk_pkg::rsp_type              result,
   output logic [5:0]                      acc_in,
   output logic [1:0]                      held_in,
   output logic [POSITION_BITS-1:0]        pos_in,
   output logic [29:0]                     addr_in,
   output logic                            run_open_in,
   output logic [POSITION_BITS-1:0]        run_start_in
);

   localparam int LW = (POSITION_BITS > 32) ? POSITION_BITS : 32;

   logic [LW-1:0]             pos_max;
   logic [LW-1:0]             ref_ext;
   logic [LW-1:0]             limit;
   logic                      drop;
   logic [POSITION_BITS-1:0]  run_len_raw;
   logic [LW-1:0]             run_len_ext;
   logic [LW-1:0]             run_start_ext;
   dnapk_pkg::base_decode_type dec;

   assign pos_max       = LW'({POSITION_BITS{1'b1}});
   assign ref_ext       = LW'(ref_len);
   assign limit         = (ref_ext < pos_max) ? ref_ext : pos_max;
   assign drop          = (LW'(pos) >= limit);
   assign run_len_raw   = pos - run_start;
   assign run_len_ext   = LW'(run_len_raw);
   assign run_start_ext = LW'(run_start);
   assign dec           = dnapk_pkg::decode_base(item.base_code);

   always_comb begin
      result       = '0;
      acc_in       = acc;
      held_in      = held;
      pos_in       = pos;
      addr_in      = addr;
      run_open_in  = run_open;
      run_start_in = run_start;

      if (item.action == dnapk_pkg::ACTION_FLUSH) begin
         if (held != 2'd0) begin
            result.byte_valid   = 1'b1;
            result.byte_address = addr;
            case (held)
               2'd1:    result.packed_byte = {acc[1:0], 6'b0};
               2'd2:    result.packed_byte = {acc[3:0], 4'b0};
               default: result.packed_byte = {acc[5:0], 2'b0};
            endcase
            addr_in = addr + 30'd1;
            acc_in  = '0;
            held_in = '0;
         end
         if (run_open) begin
            result.run_valid  = 1'b1;
            result.run_start  = run_start_ext[31:0];
            result.run_length = run_len_ext[31:0];
            run_open_in       = 1'b0;
            run_start_in      = '0;
         end
      end else if (drop) begin
         // base past the allowed length: flag it, state untouched
         result.length_error = 1'b1;
      end else begin
         if (held == 2'd3) begin
            result.byte_valid   = 1'b1;
            result.packed_byte  = {acc, dec.code};
            result.byte_address = addr;
            addr_in = addr + 30'd1;
            acc_in  = '0;
            held_in = '0;
         end else begin
            acc_in  = {acc[3:0], dec.code};
            held_in = held + 2'd1;
         end

         if (dec.ambiguous) begin
            if (!run_open) begin
               run_open_in  = 1'b1;
               run_start_in = pos;
            end
         end else if (run_open) begin
            result.run_valid  = 1'b1;
            result.run_start  = run_start_ext[31:0];
            result.run_length = run_len_ext[31:0];
            run_open_in       = 1'b0;
            run_start_in      = '0;
         end

         pos_in = pos + POSITION_BITS'(1);
      end

      has_result = result.byte_valid | result.run_valid | result.length_error;
   end

endmodule

`default_nettype wire

@@ rtl/dna_4bit_to_2bit_packer_n_runs_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Packs a stream of 4-bit one-hot nucleotide codes into bytes of four 2-bit
// codes (earliest base in bits 7..6) and reports runs of ambiguous bases
// (any code other than A=1, C=2, G=4, T=8; stored as code 0) with their start
// position and length once a run closes. A flush request pads the partial
// byte with zeros and closes an open run. A base at or beyond
// reference_length (csr port, which the user must write only while idle; the
// block does not enforce this) is dropped and answered with length_error.
// Rate: one request per clock sustained while the sink does not stall. A
// request is registered, processed by one pass of combinational logic and
// lands in the response register; rsp.ready feeds req.ready combinationally
// through the two stages, so once both hold data a stalled sink stalls the
// source in the same cycle. Requests that produce nothing (a base that
// neither fills a byte nor closes a run, an empty flush) give no response.
module dna_4bit_to_2bit_packer_n_runs_top #(
   parameter int POSITION_BITS = 32
) (
   input  wire         clock,
   input  wire         reset,
   dnapk_req_if.sink   req_ch,
   dnapk_rsp_if.source rsp_ch,
   dnapk_csr_if.sink   csr_ch
);

   // config
   logic [31:0] ref_len_ff;

   // input stage
   logic               s1_valid_ff;
   dnapk_pkg::req_type s1_item_ff;
   logic               s1_go;

   // packer state
   logic [5:0]               acc_ff, acc_in;
   logic [1:0]               held_ff, held_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [29:0]              addr_ff, addr_in;
   logic                     run_open_ff, run_open_in;
   logic [POSITION_BITS-1:0] run_start_ff, run_start_in;

   // result stage
   logic               has_result;
   dnapk_pkg::rsp_type result;
   logic               out_valid_ff;
   dnapk_pkg::rsp_type out_ff;

   // input stage drains when the result register is free or being emptied
   assign s1_go        = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_len_ff <= '0;
      end else if (csr_ch.valid) begin
         ref_len_ff <= csr_ch.reference_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_item_ff.action    <= req_ch.action;
         s1_item_ff.base_code <= req_ch.base_code;
      end
   end

   dnapk_step #(
      .POSITION_BITS(POSITION_BITS)
   ) u_step (
      .item         (s1_item_ff),
      .ref_len      (ref_len_ff),
      .acc          (acc_ff),
      .held         (held_ff),
      .pos          (pos_ff),
      .addr         (addr_ff),
      .run_open     (run_open_ff),
      .run_start    (run_start_ff),
      .has_result   (has_result),
      .result       (result),
      .acc_in       (acc_in),
      .held_in      (held_in),
      .pos_in       (pos_in),
      .addr_in      (addr_in),
      .run_open_in  (run_open_in),
      .run_start_in (run_start_in)
   );

   // state advances once per processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         held_ff      <= '0;
         pos_ff       <= '0;
         addr_ff      <= '0;
         run_open_ff  <= 1'b0;
         run_start_ff <= '0;
      end else if (s1_go) begin
         acc_ff       <= acc_in;
         held_ff      <= held_in;
         pos_ff       <= pos_in;
         addr_ff      <= addr_in;
         run_open_ff  <= run_open_in;
         run_start_ff <= run_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_go) begin
         out_valid_ff <= has_result;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         out_ff <= result;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.byte_valid   = out_ff.byte_valid;
   assign rsp_ch.packed_byte  = out_ff.packed_byte;
   assign rsp_ch.byte_address = out_ff.byte_address;
   assign rsp_ch.run_valid    = out_ff.run_valid;
   assign rsp_ch.run_start    = out_ff.run_start;
   assign rsp_ch.run_length   = out_ff.run_length;
   assign rsp_ch.length_error = out_ff.length_error;

endmodule

`default_nettype wire

@@ rtl/dnapk_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dnapk_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire        byte_valid,
   input wire [7:0]  packed_byte,
   input wire [29:0] byte_address,
   input wire        run_valid,
   input wire [31:0] run_length,
   input wire        length_error
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(packed_byte)
         && $stable(byte_address) && $stable(run_length))
      else $error("response changed while stalled");

   // a response always carries something
   a_rsp_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> byte_valid || run_valid || length_error)
      else $error("empty response");

   // a dropped base carries nothing else
   a_drop_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && length_error |-> !byte_valid && !run_valid)
      else $error("length error mixed with data");

   // a closed run has at least one base
   a_run_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_valid |-> run_length != 32'd0)
      else $error("zero-length run");

   // no byte: byte fields read zero
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !byte_valid |-> packed_byte == 8'd0 && byte_address == 30'd0)
      else $error("byte fields set without byte_valid");

endmodule

bind dna_4bit_to_2bit_packer_n_runs_top dnapk_checker u_dnapk_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .byte_valid   (rsp_ch.byte_valid),
   .packed_byte  (rsp_ch.packed_byte),
   .byte_address (rsp_ch.byte_address),
   .run_valid    (rsp_ch.run_valid),
   .run_length   (rsp_ch.run_length),
   .length_error (rsp_ch.length_error)
);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

// Block-level bench for the 4-bit to 2-bit nucleotide packer.
//
// Stimulus is queued up front by the main initial block, one phase at a time.
// A clocked driver hands each request to the block, and a clocked monitor takes
// responses off the result channel. When the block accepts a request, the driver
// runs it through a local bit-accurate model of the packer: the partial byte, the
// base counter, the byte address and the ambiguous run tracker. If the request
// yields something, the predicted response goes on a FIFO. The monitor compares
// every response field by field against the head of that FIFO.
//
// The length register is only rewritten between phases, once the bench is idle.
// Phases cover:
//   - the reset value of zero, where every base is dropped
//   - full length
//   - a limit that falls in the middle of an open run
//   - an explicit zero
//   - random settings, some set just ahead of the current position so the tail
//     of the phase runs into the limit

module tb_top;

   localparam int          CLK_HALF_NS  = 10;
   localparam int          DRAIN_CYCLES = 8;     // two-stage pipe, plus margin
   localparam int          LONG_HOLD    = 300;   // long rsp back-pressure burst
   localparam int          SIDE_REQ     = 0;
   localparam int          SIDE_RSP     = 1;
   localparam logic [31:0] POS_LIMIT    = 32'hFFFF_FFFF;  // 2^POSITION_BITS - 1

   logic clock = 1'b0;
   logic reset;

   dnapk_req_if req_ch ();
   dnapk_rsp_if rsp_ch ();
   dnapk_csr_if csr_ch ();

   dna_4bit_to_2bit_packer_n_runs_top #(
      .POSITION_BITS (32)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #CLK_HALF_NS clock = ~clock;

   // ---------------------------------------------------------------------
   // Packer model state. Everything here resets to zero.
   // ---------------------------------------------------------------------
   logic [31:0] ref_length  = '0;   // copy of the csr register
   logic [5:0]  acc_codes   = '0;   // up to three held 2-bit codes
   logic [1:0]  held_codes  = '0;
   logic [31:0] base_pos    = '0;
   logic [29:0] byte_addr   = '0;
   logic        run_is_open = 1'b0;
   logic [31:0] run_from    = '0;

   dnapk_pkg::req_type pending_bases [$];      // requests not yet offered
   dnapk_pkg::rsp_type expected_packing [$];   // predicted responses, oldest first

   int unsigned queued_total   = 0;
   int unsigned accepted_total = 0;
   int unsigned mismatch_count = 0;

   // Per-side idle control: each side runs in stretches, each either with
   // random gaps or with none.
   int unsigned stretch_left [2];
   bit          quiet_side [2];

   int unsigned        req_gap;
   int unsigned        rsp_wait;
   int unsigned        hold_left;
   int unsigned        holds_done;
   logic               hold_active;
   dnapk_pkg::req_type current_req;

   function automatic int unsigned draw_wait(input int side);
      if (stretch_left[side] == 0) begin
         quiet_side[side]   = ($urandom_range(0, 2) == 0);
         stretch_left[side] = $urandom_range(10, 50);
      end
      stretch_left[side]--;
      return quiet_side[side] ? 0 : $urandom_range(0, 19);
   endfunction

   // Runs one accepted request through the model. Returns 1 if the block
   // should answer it.
   function automatic bit pack_base(input dnapk_pkg::req_type r,
                                    output dnapk_pkg::rsp_type res);
      logic [1:0]  code;
      logic        ambiguous;
      logic [7:0]  partial;
      logic [31:0] limit;
      bit          hit;
      res = '0;
      hit = 1'b0;

      if (r.action == dnapk_pkg::ACTION_FLUSH) begin
         // Pad the partial byte with zero codes, then close any open run.
         if (held_codes != 0) begin
            partial          = {2'b00, acc_codes};
            res.byte_valid   = 1'b1;
            res.packed_byte  = partial << (2 * (4 - int'(held_codes)));
            res.byte_address = byte_addr;
            byte_addr        = byte_addr + 1'b1;
            acc_codes        = '0;
            held_codes       = '0;
            hit              = 1'b1;
         end
         if (run_is_open) begin
            res.run_valid  = 1'b1;
            res.run_start  = run_from;
            res.run_length = base_pos - run_from;
            run_is_open    = 1'b0;
            run_from       = '0;
            hit            = 1'b1;
         end
         return hit;
      end

      // The counter is 32 bits wide, so the limit is capped at its top value.
      // A dropped base changes no state, and an open run stays open.
      limit = (ref_length < POS_LIMIT) ? ref_length : POS_LIMIT;
      if (base_pos >= limit) begin
         res.length_error = 1'b1;
         return 1'b1;
      end

      ambiguous = 1'b0;
      case (r.base_code)
         dnapk_pkg::NT_A: code = 2'd0;
         dnapk_pkg::NT_C: code = 2'd1;
         dnapk_pkg::NT_G: code = 2'd2;
         dnapk_pkg::NT_T: code = 2'd3;
         default: begin
            code      = 2'd0;
            ambiguous = 1'b1;
         end
      endcase

      if (held_codes == 2'd3) begin
         res.byte_valid   = 1'b1;
         res.packed_byte  = {acc_codes, code};
         res.byte_address = byte_addr;
         byte_addr        = byte_addr + 1'b1;
         acc_codes        = '0;
         held_codes       = '0;
         hit              = 1'b1;
      end else begin
         acc_codes  = {acc_codes[3:0], code};
         held_codes = held_codes + 1'b1;
      end

      if (ambiguous) begin
         if (!run_is_open) begin
            run_is_open = 1'b1;
            run_from    = base_pos;
         end
      end else if (run_is_open) begin
         // A plain base ends the run. It still counts in base_pos, but it
         // is not part of the run length.
         res.run_valid  = 1'b1;
         res.run_start  = run_from;
         res.run_length = base_pos - run_from;
         run_is_open    = 1'b0;
         run_from       = '0;
         hit            = 1'b1;
      end

      base_pos = base_pos + 1'b1;
      return hit;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   // ---------------------------------------------------------------------
   // Driver. Requests are offered from pending_bases. The model sees each
   // request at the same edge where the block accepts it.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      dnapk_pkg::rsp_type res;
      if (reset) begin
         req_ch.valid     <= 1'b0;
         req_ch.action    <= dnapk_pkg::ACTION_BASE;
         req_ch.base_code <= '0;
         req_gap          <= 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            if (pack_base(current_req, res))
               expected_packing.push_back(res);
            accepted_total++;
         end
         if (req_gap != 0) begin
            req_gap      <= req_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_bases.size() != 0) begin
            current_req       = pending_bases.pop_front();
            req_ch.action    <= current_req.action;
            req_ch.base_code <= current_req.base_code;
            req_ch.valid     <= 1'b1;
            req_gap          <= draw_wait(SIDE_REQ);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor. After each accepted response, ready may drop for a random number
   // of cycles. It also stays low while a long hold is in progress.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      dnapk_pkg::rsp_type got;
      dnapk_pkg::rsp_type want;
      int unsigned        w;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait     <= 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.byte_valid, rsp_ch.packed_byte, rsp_ch.byte_address,
                rsp_ch.run_valid, rsp_ch.run_start, rsp_ch.run_length,
                rsp_ch.length_error};
         if (expected_packing.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            want = expected_packing.pop_front();
            check_field("byte_valid",   got.byte_valid,   want.byte_valid);
            check_field("packed_byte",  got.packed_byte,  want.packed_byte);
            check_field("byte_address", got.byte_address, want.byte_address);
            check_field("run_valid",    got.run_valid,    want.run_valid);
            check_field("run_start",    got.run_start,    want.run_start);
            check_field("run_length",   got.run_length,   want.run_length);
            check_field("length_error", got.length_error, want.length_error);
         end
         w = draw_wait(SIDE_RSP);
         // the cycle right after this edge is the first idle one
         rsp_wait     <= (w == 0) ? 0 : w - 1;
         rsp_ch.ready <= (w == 0) && !hold_active;
      end else if (rsp_wait != 0) begin
         rsp_wait     <= rsp_wait - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !hold_active;
      end
   end

   // Two long receiver holds, each started partway through a random phase.
   // The driver keeps offering requests throughout, so both pipe stages fill
   // up and req.ready drops.
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if ((holds_done == 0 && accepted_total >= 200) ||
                   (holds_done == 1 && accepted_total >= 600)) begin
         hold_left  <= LONG_HOLD;
         holds_done <= holds_done + 1;
      end
   end

   assign hold_active = (hold_left != 0);

   // ---------------------------------------------------------------------
   // Stimulus and sequencing
   // ---------------------------------------------------------------------
   function automatic void queue_request(input logic act, input logic [3:0] code);
      dnapk_pkg::req_type r;
      r.action    = act;
      r.base_code = code;
      pending_bases.push_back(r);
      queued_total++;
   endfunction

   // Wait until every queued request has been accepted and every expected
   // response has come back. Some requests produce no response and may
   // still be in the pipe at that point, so let the pipe drain afterwards.
   task automatic wait_idle();
      do @(posedge clock);
      while (accepted_total != queued_total || expected_packing.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_ref_length(input logic [31:0] value);
      wait_idle();
      csr_ch.valid            <= 1'b1;
      csr_ch.reference_length <= value;
      do @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      ref_length = value;
   endtask

   // One random segment of the stream. Kinds: a stretch of plain bases,
   // a run of ambiguous codes, or a flush. Returns the number of requests
   // queued.
   function automatic int unsigned queue_segment();
      int unsigned kind;
      int unsigned len;
      logic [3:0]  c;
      kind = $urandom_range(0, 19);
      if (kind < 11) begin
         len = $urandom_range(1, 12);
         repeat (len)
            queue_request(dnapk_pkg::ACTION_BASE, 4'b0001 << $urandom_range(0, 3));
      end else if (kind < 18) begin
         len = $urandom_range(1, 8);
         repeat (len) begin
            do c = 4'($urandom_range(0, 15));
            while (c == dnapk_pkg::NT_A || c == dnapk_pkg::NT_C ||
                   c == dnapk_pkg::NT_G || c == dnapk_pkg::NT_T);
            queue_request(dnapk_pkg::ACTION_BASE, c);
         end
      end else begin
         len = 1;
         queue_request(dnapk_pkg::ACTION_FLUSH, 4'($urandom_range(0, 15)));
      end
      return len;
   endfunction

   initial begin
      int unsigned phase_count;
      int unsigned mode;
      logic [31:0] lim;

      reset                   = 1'b1;
      csr_ch.valid            = 1'b0;
      csr_ch.reference_length = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Length register still at its reset value of zero: bases get dropped,
      // and a flush with nothing held gives no response.
      queue_request(dnapk_pkg::ACTION_BASE, dnapk_pkg::NT_A);
      queue_request(dnapk_pkg::ACTION_BASE, 4'hF);
      queue_request(dnapk_pkg::ACTION_FLUSH, 4'h0);

      write_ref_length(32'hFFFF_FFFF);
      // One byte of each nucleotide (A C G T).
      queue_request(dnapk_pkg::ACTION_BASE, dnapk_pkg::NT_A);
      queue_request(dnapk_pkg::ACTION_BASE, dnapk_pkg::NT_C);
      queue_request(dnapk_pkg::ACTION_BASE, dnapk_pkg::NT_G);
      queue_request(dnapk_pkg::ACTION_BASE, dnapk_pkg::NT_T);
      // An all-ambiguous byte, with the run closed by the T that follows.
      queue_request(dnapk_pkg::ACTION_BASE, 4'h0);
      queue_request(dnapk_pkg::ACTION_BASE, 4'h3);
      queue_request(dnapk_pkg::ACTION_BASE, 4'h5);
      queue_request(dnapk_pkg::ACTION_BASE, 4'h6);
      queue_request(dnapk_pkg::ACTION_BASE, dnapk_pkg::NT_T);
      // Flush that pads a partial byte and closes a run in one response.
      queue_request(dnapk_pkg::ACTION_BASE, 4'h7);
      queue_request(dnapk_pkg::ACTION_BASE, 4'h9);
      queue_request(dnapk_pkg::ACTION_FLUSH, 4'hF);
      // Flush with nothing held and no open run.
      queue_request(dnapk_pkg::ACTION_FLUSH, dnapk_pkg::NT_C);
      // A run that straddles a byte boundary. A G then ends it, and a flush
      // pads out the last byte.
      queue_request(dnapk_pkg::ACTION_BASE, 4'hA);
      queue_request(dnapk_pkg::ACTION_BASE, 4'hB);
      queue_request(dnapk_pkg::ACTION_BASE, 4'hC);
      queue_request(dnapk_pkg::ACTION_BASE, 4'hD);
      queue_request(dnapk_pkg::ACTION_BASE, 4'hE);
      queue_request(dnapk_pkg::ACTION_BASE, 4'hF);
      queue_request(dnapk_pkg::ACTION_BASE, dnapk_pkg::NT_G);
      queue_request(dnapk_pkg::ACTION_FLUSH, 4'h0);

      // Limit set three bases ahead, so it lands while a run is open. The
      // dropped bases must leave the run open, and the flush closes it.
      wait_idle();
      write_ref_length(base_pos + 32'd3);
      queue_request(dnapk_pkg::ACTION_BASE, dnapk_pkg::NT_A);
      queue_request(dnapk_pkg::ACTION_BASE, 4'h0);
      queue_request(dnapk_pkg::ACTION_BASE, 4'hE);
      queue_request(dnapk_pkg::ACTION_BASE, 4'h5);
      queue_request(dnapk_pkg::ACTION_BASE, dnapk_pkg::NT_C);
      queue_request(dnapk_pkg::ACTION_FLUSH, 4'h8);

      write_ref_length(32'h0000_0000);
      queue_request(dnapk_pkg::ACTION_BASE, dnapk_pkg::NT_G);
      queue_request(dnapk_pkg::ACTION_FLUSH, 4'h1);

      // Random phases, about 850 requests in total.
      repeat (8) begin
         mode = $urandom_range(0, 3);
         wait_idle();
         if (mode == 0)
            lim = base_pos + $urandom_range(20, 100);   // limit hit mid-phase
         else if (mode == 1)
            lim = $urandom;
         else
            lim = 32'hFFFF_FFFF;
         write_ref_length(lim);
         phase_count = 0;
         while (phase_count < 98)
            phase_count += queue_segment();
         if ($urandom_range(0, 1) == 0)
            queue_request(dnapk_pkg::ACTION_FLUSH, 4'($urandom_range(0, 15)));
      end
      queue_request(dnapk_pkg::ACTION_FLUSH, 4'h0);

      wait_idle();
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Timeout: far longer than the slowest legal run, even with maximum
   // gaps and stalls on every request.
   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
